@@ rtl/ypm_pkg.sv @@
// Shared types and constants of the YUV 4:2:0 PSNR meter.
package ypm_pkg;

  localparam int unsigned CNT_W = 48;  // sample count into the PSNR unit
  localparam int unsigned DVD_W = 48;  // dividend of the mean divider
  localparam int unsigned DVS_W = 24;  // divisor of the mean divider
  localparam logic [31:0] K_DB_Q24 = 32'd50504453;  // 10*log10(2) in Q24

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_PEAK   = 2'd2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef enum logic [3:0] {
    M_IDLE, M_MUL_LO, M_MUL_HI, M_SUM, M_NORM, M_SQ, M_SQ_ADJ,
    M_MUL_K, M_ROUND, M_DIV, M_DONE
  } math_state_e;

  typedef enum logic [2:0] {
    T_RUN, T_PLANE_CALC, T_PLANE_EMIT, T_FIN_START, T_FIN_PSNR,
    T_FIN_DIVGO, T_FIN_DIV, T_FIN_EMIT
  } top_state_e;

  typedef struct packed {
    logic             start;
    logic             div;
    logic [15:0]      peak;
    logic [CNT_W-1:0] count;
    logic [63:0]      den;
    logic [DVD_W-1:0] dvd;
    logic [DVS_W-1:0] dvs;
  } math_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] result;
  } math_rsp_t;

  typedef struct packed {
    logic [1:0]  plane;
    logic        is_summary;
    logic [63:0] error_sum;
    logic [15:0] psnr_q8;
    logic [15:0] mean_psnr_q8;
    logic [15:0] frame_number;
    logic        zero_error;
    logic        no_frames;
    logic        last;
  } out_item_t;

endpackage

@@ rtl/ypm_if.sv @@
// Handshake channel interfaces: sample input, result output, register writes.
interface ypm_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] test_sample;
  logic [7:0] ref_sample;
  modport source (output valid, opcode, test_sample, ref_sample, input ready);
  modport sink   (input valid, opcode, test_sample, ref_sample, output ready);
endinterface

interface ypm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  plane;
  logic        is_summary;
  logic [63:0] error_sum;
  logic [15:0] psnr_q8;
  logic [15:0] mean_psnr_q8;
  logic [15:0] frame_number;
  logic        zero_error;
  logic        no_frames;
  logic        last;
  modport source (output valid, plane, is_summary, error_sum, psnr_q8, mean_psnr_q8,
                  frame_number, zero_error, no_frames, last, input ready);
  modport sink   (input valid, plane, is_summary, error_sum, psnr_q8, mean_psnr_q8,
                  frame_number, zero_error, no_frames, last, output ready);
endinterface

interface ypm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/ypm_math.sv @@
// Shared multiplier sequencer: PSNR from log2 by squaring, and mean divider.
module ypm_math (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ypm_pkg::math_req_t req_i,
  output ypm_pkg::math_rsp_t rsp_o
);

  ypm_pkg::math_state_e st_q, st_d;

  logic [15:0] peak_q;
  logic [ypm_pkg::CNT_W-1:0] cnt_q;
  logic [63:0] den_q, x_q, acc_q, prod_q, prod_d;
  logic [5:0]  e_q, it_q;
  logic [30:0] m_q;
  logic [23:0] frac_q;
  logic        sel_q;
  logic [29:0] ln_q, diff_q;
  logic [24:0] rem_q;
  logic [ypm_pkg::DVS_W-1:0] dvs_q;
  logic [15:0] res_q;

  logic [31:0] mul_a, mul_b;
  logic [31:0] mm;
  logic [23:0] frac_n;
  logic [29:0] lg_n;
  logic [63:0] num;
  logic [63:0] rnd;
  logic [24:0] rs;
  logic        ge;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_q)
      ypm_pkg::M_MUL_LO: begin
        mul_a = {16'd0, peak_q};
        mul_b = {8'd0, cnt_q[23:0]};
      end
      ypm_pkg::M_MUL_HI: begin
        mul_a = {16'd0, peak_q};
        mul_b = {8'd0, cnt_q[47:24]};
      end
      ypm_pkg::M_SQ: begin
        mul_a = {1'b0, m_q};
        mul_b = {1'b0, m_q};
      end
      ypm_pkg::M_MUL_K: begin
        mul_a = {2'd0, diff_q};
        mul_b = ypm_pkg::K_DB_Q24;
      end
      default: ;
    endcase
    prod_d = mul_a * mul_b;
  end

  assign mm     = prod_q[61:30];
  assign frac_n = {frac_q[22:0], mm[31]};
  assign lg_n   = {e_q, frac_n};
  assign num    = acc_q + (prod_q << 24);
  assign rnd    = prod_q + 64'h0000_0080_0000_0000;
  assign rs     = {rem_q[23:0], x_q[47]};
  assign ge     = rs >= {1'b0, dvs_q};

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ypm_pkg::M_IDLE:
        if (req_i.start) st_d = req_i.div ? ypm_pkg::M_DIV : ypm_pkg::M_MUL_LO;
      ypm_pkg::M_MUL_LO: st_d = ypm_pkg::M_MUL_HI;
      ypm_pkg::M_MUL_HI: st_d = ypm_pkg::M_SUM;
      ypm_pkg::M_SUM:    st_d = (num == '0) ? ypm_pkg::M_DONE : ypm_pkg::M_NORM;
      ypm_pkg::M_NORM:   if (x_q[63]) st_d = ypm_pkg::M_SQ;
      ypm_pkg::M_SQ:     st_d = ypm_pkg::M_SQ_ADJ;
      ypm_pkg::M_SQ_ADJ: begin
        if (it_q != 6'd23) st_d = ypm_pkg::M_SQ;
        else if (!sel_q) st_d = ypm_pkg::M_NORM;
        else st_d = (ln_q <= lg_n) ? ypm_pkg::M_DONE : ypm_pkg::M_MUL_K;
      end
      ypm_pkg::M_MUL_K:  st_d = ypm_pkg::M_ROUND;
      ypm_pkg::M_ROUND:  st_d = ypm_pkg::M_DONE;
      ypm_pkg::M_DIV:    if (it_q == 6'd47) st_d = ypm_pkg::M_DONE;
      ypm_pkg::M_DONE:   st_d = ypm_pkg::M_IDLE;
      default:           st_d = ypm_pkg::M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ypm_pkg::M_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (st_q)
      ypm_pkg::M_IDLE: begin
        peak_q <= req_i.peak;
        cnt_q  <= req_i.count;
        den_q  <= req_i.den;
        dvs_q  <= req_i.dvs;
        x_q    <= {16'd0, req_i.dvd};
        rem_q  <= '0;
        it_q   <= '0;
        sel_q  <= 1'b0;
        res_q  <= '0;
      end
      ypm_pkg::M_MUL_HI: acc_q <= prod_q;
      ypm_pkg::M_SUM: begin
        x_q <= num;
        e_q <= 6'd63;
      end
      ypm_pkg::M_NORM: begin
        if (x_q[63]) begin
          m_q    <= x_q[63:33];
          frac_q <= '0;
          it_q   <= '0;
        end else begin
          x_q <= x_q << 1;
          e_q <= e_q - 6'd1;
        end
      end
      ypm_pkg::M_SQ_ADJ: begin
        frac_q <= frac_n;
        m_q    <= mm[31] ? mm[31:1] : mm[30:0];
        it_q   <= it_q + 6'd1;
        if (it_q == 6'd23) begin
          if (!sel_q) begin
            ln_q  <= lg_n;
            x_q   <= den_q;
            e_q   <= 6'd63;
            sel_q <= 1'b1;
          end else begin
            diff_q <= ln_q - lg_n;
          end
        end
      end
      ypm_pkg::M_ROUND: res_q <= (|rnd[63:56]) ? 16'hFFFF : rnd[55:40];
      ypm_pkg::M_DIV: begin
        rem_q <= ge ? rs - {1'b0, dvs_q} : rs;
        x_q   <= {x_q[62:0], ge};
        it_q  <= it_q + 6'd1;
        if (it_q == 6'd47) res_q <= {x_q[14:0], ge};
      end
      default: ;
    endcase
  end

  assign rsp_o.done   = (st_q == ypm_pkg::M_DONE);
  assign rsp_o.result = res_q;

endmodule

@@ rtl/yuv420_psnr_meter_unit.sv @@
// Top level of the YUV 4:2:0 PSNR meter: sample accumulation, totals, result register.
//
// Channels: sample_i takes (opcode, test_sample, ref_sample); result_o gives
// per-plane and summary results; cfg_i writes frame_width, frame_height and
// peak_squared (index 0, 1, 2), always ready; the user must write only while
// the block is idle, as the block itself does not enforce it. Sample pairs
// inside a plane are taken one per cycle and give no result. The pair that
// ends a plane makes the block busy until its result is registered; a plane
// with zero error skips the PSNR unit, which normalises num and den one bit a cycle
// and runs 24 squarings per log2 on one shared 32x32 multiplier. A finish item
// gives, per plane, a PSNR computation (none for zero total error), a restoring
// mean divide (neither with no frames) and a result, the third flagged last.
// A result sits in an output register; further samples are still taken while
// it waits, and the block holds only when a new result finds it full.
// Reset returns the registers to 352x288, peak 65025, and clears all totals;
// no clearing pass is needed.
module yuv420_psnr_meter_unit #(
  parameter int unsigned MAX_DIM    = 4096,
  parameter int unsigned MAX_FRAMES = 65535
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ypm_in_if.sink    sample_i,
  ypm_out_if.source result_o,
  ypm_cfg_if.sink   cfg_i
);

  localparam int unsigned DW  = $clog2(MAX_DIM);
  localparam int unsigned DMW = $clog2(MAX_DIM + 1);
  localparam int unsigned FW  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned PEW = 2 * DMW + 16;
  localparam int unsigned TSW = 2 * DMW + FW;
  localparam int unsigned SW  = 16 + FW;

  ypm_pkg::top_state_e st_q, st_d;

  logic [12:0] fw_q, fh_q;
  logic [15:0] peak_q;
  logic [DW-1:0] col_q, row_q;
  logic [1:0] cp_q, fp_q;
  logic [PEW-1:0] perr_q;
  logic [63:0] terr_q [3];
  logic [SW-1:0] psum_q [3];
  logic [TSW-1:0] tsmp_q [3];
  logic [PEW-1:0] pend_err_q [3];
  logic [15:0] pend_psnr_q [3];
  logic [FW-1:0] frames_q;
  logic [PEW-1:0] err_q;
  logic [15:0] psnr_q, mean_q;
  logic out_valid_q;
  ypm_pkg::out_item_t out_q;

  ypm_pkg::math_req_t mreq;
  ypm_pkg::math_rsp_t mrsp;

  logic [DMW-1:0] w, h, pw, ph;
  logic [2*DMW-1:0] cnt_wh, cnt_c, cnt_p;
  logic [8:0] dif;
  logic [15:0] sq;
  logic [PEW-1:0] perr_n;
  logic in_acc, cfg_acc, slot_free, plane_end, frames_room, fin_zero, out_load;

  function automatic logic [DMW-1:0] clamp_dim(input logic [12:0] v);
    logic [31:0] v32;
    v32 = {19'd0, v};
    if (v32 < 32'd2) return DMW'(2);
    else if (v32 > MAX_DIM) return DMW'(MAX_DIM);
    else return DMW'(v32);
  endfunction

  assign w      = clamp_dim(fw_q);
  assign h      = clamp_dim(fh_q);
  assign pw     = (cp_q != 2'd0) ? (w >> 1) : w;
  assign ph     = (cp_q != 2'd0) ? (h >> 1) : h;
  assign cnt_wh = w * h;
  assign cnt_c  = (w >> 1) * (h >> 1);
  assign cnt_p  = pw * ph;

  assign dif    = {1'b0, sample_i.test_sample} - {1'b0, sample_i.ref_sample};
  assign sq     = $signed(dif) * $signed(dif);
  assign perr_n = perr_q + PEW'(sq);

  assign in_acc      = sample_i.valid && sample_i.ready;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign slot_free   = !out_valid_q || result_o.ready;
  assign plane_end   = (32'(col_q) + 32'd1 >= 32'(pw)) && (32'(row_q) + 32'd1 >= 32'(ph));
  assign frames_room = frames_q < FW'(MAX_FRAMES);
  assign fin_zero    = (terr_q[fp_q] == '0);
  assign out_load    = slot_free &&
                       (st_q == ypm_pkg::T_PLANE_EMIT || st_q == ypm_pkg::T_FIN_EMIT);

  assign sample_i.ready = (st_q == ypm_pkg::T_RUN);
  assign cfg_i.ready    = 1'b1;

  ypm_math u_math (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  always_comb begin
    st_d       = st_q;
    mreq.start = 1'b0;
    mreq.div   = 1'b0;
    mreq.peak  = peak_q;
    mreq.count = ypm_pkg::CNT_W'(cnt_p);
    mreq.den   = 64'(perr_n);
    mreq.dvd   = ypm_pkg::DVD_W'(psum_q[fp_q] + SW'(frames_q >> 1));
    mreq.dvs   = ypm_pkg::DVS_W'(frames_q);
    unique case (st_q)
      ypm_pkg::T_RUN: begin
        if (in_acc) begin
          if (sample_i.opcode == ypm_pkg::OP_FINISH) begin
            st_d = ypm_pkg::T_FIN_START;
          end else if (plane_end) begin
            if (perr_n == '0) begin
              st_d = ypm_pkg::T_PLANE_EMIT;
            end else begin
              mreq.start = 1'b1;
              st_d = ypm_pkg::T_PLANE_CALC;
            end
          end
        end
      end
      ypm_pkg::T_PLANE_CALC: if (mrsp.done) st_d = ypm_pkg::T_PLANE_EMIT;
      ypm_pkg::T_PLANE_EMIT: if (slot_free) st_d = ypm_pkg::T_RUN;
      ypm_pkg::T_FIN_START: begin
        mreq.count = ypm_pkg::CNT_W'(tsmp_q[fp_q]);
        mreq.den   = terr_q[fp_q];
        if (frames_q == '0) begin
          st_d = ypm_pkg::T_FIN_EMIT;
        end else if (fin_zero) begin
          st_d = ypm_pkg::T_FIN_DIVGO;
        end else begin
          mreq.start = 1'b1;
          st_d = ypm_pkg::T_FIN_PSNR;
        end
      end
      ypm_pkg::T_FIN_PSNR: if (mrsp.done) st_d = ypm_pkg::T_FIN_DIVGO;
      ypm_pkg::T_FIN_DIVGO: begin
        mreq.start = 1'b1;
        mreq.div   = 1'b1;
        st_d = ypm_pkg::T_FIN_DIV;
      end
      ypm_pkg::T_FIN_DIV: if (mrsp.done) st_d = ypm_pkg::T_FIN_EMIT;
      ypm_pkg::T_FIN_EMIT: begin
        if (slot_free) st_d = (fp_q == 2'd2) ? ypm_pkg::T_RUN : ypm_pkg::T_FIN_START;
      end
      default: st_d = ypm_pkg::T_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ypm_pkg::T_RUN;
      fw_q        <= 13'd352;
      fh_q        <= 13'd288;
      peak_q      <= 16'd65025;
      col_q       <= '0;
      row_q       <= '0;
      cp_q        <= '0;
      fp_q        <= '0;
      perr_q      <= '0;
      frames_q    <= '0;
      out_valid_q <= 1'b0;
      for (int p = 0; p < 3; p++) begin
        terr_q[p]      <= '0;
        psum_q[p]      <= '0;
        tsmp_q[p]      <= '0;
        pend_err_q[p]  <= '0;
        pend_psnr_q[p] <= '0;
      end
    end else begin
      st_q <= st_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (result_o.ready) out_valid_q <= 1'b0;

      if (cfg_acc) begin
        unique case (cfg_i.index)
          ypm_pkg::CFG_WIDTH: begin
            fw_q <= cfg_i.data[12:0];
            col_q <= '0; row_q <= '0; cp_q <= '0; perr_q <= '0;
          end
          ypm_pkg::CFG_HEIGHT: begin
            fh_q <= cfg_i.data[12:0];
            col_q <= '0; row_q <= '0; cp_q <= '0; perr_q <= '0;
          end
          ypm_pkg::CFG_PEAK: peak_q <= cfg_i.data;
          default: ;
        endcase
      end

      unique case (st_q)
        ypm_pkg::T_RUN: begin
          if (in_acc) begin
            if (sample_i.opcode == ypm_pkg::OP_FINISH) begin
              fp_q <= '0;
            end else if (!plane_end) begin
              perr_q <= perr_n;
              if (32'(col_q) + 32'd1 >= 32'(pw)) begin
                col_q <= '0;
                row_q <= row_q + DW'(1);
              end else begin
                col_q <= col_q + DW'(1);
              end
            end else begin
              col_q  <= '0;
              row_q  <= '0;
              perr_q <= '0;
            end
          end
        end
        ypm_pkg::T_PLANE_EMIT: begin
          if (slot_free) begin
            pend_err_q[cp_q] <= err_q;
            pend_psnr_q[cp_q] <= psnr_q;
            if (cp_q != 2'd2) begin
              cp_q <= cp_q + 2'd1;
            end else begin
              cp_q <= '0;
              if (frames_room) begin
                frames_q <= frames_q + FW'(1);
                for (int p = 0; p < 2; p++) begin
                  terr_q[p] <= terr_q[p] + 64'(pend_err_q[p]);
                  psum_q[p] <= psum_q[p] + SW'(pend_psnr_q[p]);
                end
                terr_q[2] <= terr_q[2] + 64'(err_q);
                psum_q[2] <= psum_q[2] + SW'(psnr_q);
                tsmp_q[0] <= tsmp_q[0] + TSW'(cnt_wh);
                tsmp_q[1] <= tsmp_q[1] + TSW'(cnt_c);
                tsmp_q[2] <= tsmp_q[2] + TSW'(cnt_c);
              end
            end
          end
        end
        ypm_pkg::T_FIN_EMIT: begin
          if (slot_free) begin
            if (fp_q == 2'd2) begin
              // finish clears the whole video
              fp_q <= '0; col_q <= '0; row_q <= '0; cp_q <= '0; perr_q <= '0;
              frames_q <= '0;
              for (int p = 0; p < 3; p++) begin
                terr_q[p]      <= '0;
                psum_q[p]      <= '0;
                tsmp_q[p]      <= '0;
                pend_err_q[p]  <= '0;
                pend_psnr_q[p] <= '0;
              end
            end else begin
              fp_q <= fp_q + 2'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ypm_pkg::T_RUN: begin
        err_q  <= perr_n;
        psnr_q <= 16'hFFFF;
      end
      ypm_pkg::T_PLANE_CALC: if (mrsp.done) psnr_q <= mrsp.result;
      ypm_pkg::T_PLANE_EMIT: begin
        if (slot_free) begin
          out_q.plane        <= cp_q;
          out_q.is_summary   <= 1'b0;
          out_q.error_sum    <= 64'(err_q);
          out_q.psnr_q8      <= psnr_q;
          out_q.mean_psnr_q8 <= '0;
          out_q.frame_number <= 16'(frames_q);
          out_q.zero_error   <= (err_q == '0);
          out_q.no_frames    <= 1'b0;
          out_q.last         <= 1'b1;
        end
      end
      ypm_pkg::T_FIN_START: begin
        psnr_q <= (frames_q != '0 && fin_zero) ? 16'hFFFF : 16'd0;
        mean_q <= '0;
      end
      ypm_pkg::T_FIN_PSNR: if (mrsp.done) psnr_q <= mrsp.result;
      ypm_pkg::T_FIN_DIV: if (mrsp.done) mean_q <= mrsp.result;
      ypm_pkg::T_FIN_EMIT: begin
        if (slot_free) begin
          out_q.plane        <= fp_q;
          out_q.is_summary   <= 1'b1;
          out_q.error_sum    <= (frames_q != '0) ? terr_q[fp_q] : 64'd0;
          out_q.psnr_q8      <= psnr_q;
          out_q.mean_psnr_q8 <= mean_q;
          out_q.frame_number <= 16'(frames_q);
          out_q.zero_error   <= (frames_q != '0) && fin_zero;
          out_q.no_frames    <= (frames_q == '0);
          out_q.last         <= (fp_q == 2'd2);
        end
      end
      default: ;
    endcase
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.plane        = out_q.plane;
  assign result_o.is_summary   = out_q.is_summary;
  assign result_o.error_sum    = out_q.error_sum;
  assign result_o.psnr_q8      = out_q.psnr_q8;
  assign result_o.mean_psnr_q8 = out_q.mean_psnr_q8;
  assign result_o.frame_number = out_q.frame_number;
  assign result_o.zero_error   = out_q.zero_error;
  assign result_o.no_frames    = out_q.no_frames;
  assign result_o.last         = out_q.last;

endmodule

@@ tb/yuv420_psnr_meter_unit_test.sv @@
// Self-checking testbench of the YUV 4:2:0 PSNR meter with a built-in predictor.
module yuv420_psnr_meter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_DIM    = 4096;
  localparam int unsigned MAX_FRAMES = 65535;
  localparam int          SETTLE     = 250;   // cycles after the last result of a phase
  localparam int          HOLD_LEN   = 400;
  localparam int          WDOG_LIMIT = 4000;

  typedef struct packed {
    logic       op;
    logic [7:0] tst;
    logic [7:0] rfs;
  } pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ypm_in_if  smp ();
  ypm_out_if res ();
  ypm_cfg_if cfg ();

  yuv420_psnr_meter_unit #(.MAX_DIM(MAX_DIM), .MAX_FRAMES(MAX_FRAMES)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .sample_i(smp.sink), .result_o(res.source),
    .cfg_i(cfg.sink)
  );

  always #1 clk_i = ~clk_i;

  pair_t              pair_q[$];
  ypm_pkg::out_item_t result_q[$];
  int                 n_err = 0;
  bit                 quiet = 1'b0;
  bit                 hold_go = 1'b0;

  // ---------------- predictor ----------------
  logic [12:0]       wid_r, hgt_r;
  logic [15:0]       peak_r;
  int unsigned       col_n, row_n, cur_pl, frames_n;
  longint unsigned   pl_err, tot_err[3], psnr_acc[3], tot_cnt[3], pend_err[3];
  logic [15:0]       pend_psnr[3];

  function automatic int unsigned clamp_dim(logic [12:0] v);
    if (v < 2) return 2;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic longint unsigned log2_q24(longint unsigned x);
    int e = 63;
    longint unsigned m, frac = 0;
    while (e > 0 && !x[e]) e--;
    m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    repeat (24) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= 64'h8000_0000) begin
        frac |= 1;
        m >>= 1;
      end
    end
    return (longint'(e) << 24) | frac;
  endfunction

  function automatic logic [15:0] psnr_db(longint unsigned num, longint unsigned den);
    longint unsigned ln, ld, p;
    if (num == 0) return 16'd0;
    ln = log2_q24(num);
    ld = log2_q24(den);
    if (ln <= ld) return 16'd0;
    p = ((ln - ld) * longint'(ypm_pkg::K_DB_Q24) + (64'd1 << 39)) >> 40;
    return (p > 65535) ? 16'hFFFF : p[15:0];
  endfunction

  task automatic clear_pos();
    col_n = 0; row_n = 0; cur_pl = 0; pl_err = 0;
  endtask

  task automatic clear_all();
    clear_pos();
    for (int p = 0; p < 3; p++) begin
      tot_err[p] = 0; psnr_acc[p] = 0; tot_cnt[p] = 0; pend_err[p] = 0; pend_psnr[p] = 0;
    end
    frames_n = 0;
  endtask

  task automatic expect_result(int unsigned pl, bit summ, longint unsigned err,
                               logic [15:0] ps, logic [15:0] mean, int unsigned fn,
                               bit zero, bit nof, bit lst);
    ypm_pkg::out_item_t o;
    o.plane = pl[1:0]; o.is_summary = summ; o.error_sum = err; o.psnr_q8 = ps;
    o.mean_psnr_q8 = mean; o.frame_number = fn[15:0]; o.zero_error = zero;
    o.no_frames = nof; o.last = lst;
    result_q.push_back(o);
  endtask

  task automatic predict_transfer(pair_t it);
    int unsigned w, h, pw, ph, mean, d;
    longint unsigned err, cnt;
    logic [15:0] ps;
    w = clamp_dim(wid_r);
    h = clamp_dim(hgt_r);
    pw = cur_pl ? (w >> 1) : w;
    ph = cur_pl ? (h >> 1) : h;
    if (it.op == ypm_pkg::OP_FINISH) begin
      for (int p = 0; p < 3; p++) begin
        if (frames_n == 0) expect_result(p, 1, 0, 0, 0, 0, 0, 1, p == 2);
        else begin
          err = tot_err[p];
          ps = (err == 0) ? 16'hFFFF : psnr_db(longint'(peak_r) * tot_cnt[p], err);
          mean = (psnr_acc[p] + frames_n / 2) / frames_n;
          expect_result(p, 1, err, ps, mean[15:0], frames_n, err == 0, 0, p == 2);
        end
      end
      clear_all();
      return;
    end
    d = (it.tst > it.rfs) ? it.tst - it.rfs : it.rfs - it.tst;
    pl_err += d * d;
    col_n++;
    if (col_n < pw) return;
    col_n = 0;
    row_n++;
    if (row_n < ph) return;
    row_n = 0;
    cnt = longint'(pw) * ph;
    err = pl_err;
    ps = (err == 0) ? 16'hFFFF : psnr_db(longint'(peak_r) * cnt, err);
    pend_err[cur_pl] = err;
    pend_psnr[cur_pl] = ps;
    expect_result(cur_pl, 0, err, ps, 0, frames_n, err == 0, 0, 1);
    pl_err = 0;
    if (cur_pl < 2) cur_pl++;
    else begin
      cur_pl = 0;
      if (frames_n < MAX_FRAMES) begin
        for (int p = 0; p < 3; p++) begin
          tot_err[p] += pend_err[p];
          psnr_acc[p] += pend_psnr[p];
          tot_cnt[p] += p ? longint'(w >> 1) * (h >> 1) : longint'(w) * h;
        end
        frames_n++;
      end
    end
  endtask

  // ---------------- sample driver ----------------
  int  in_gap = 0;
  bit  in_taken = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni && (!smp.valid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        smp.valid <= 1'b0;
      end else if (pair_q.size() != 0) begin
        pair_t it;
        it = pair_q.pop_front();
        smp.opcode <= it.op;
        smp.test_sample <= it.tst;
        smp.ref_sample <= it.rfs;
        smp.valid <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 10);
      end else begin
        smp.valid <= 1'b0;
      end
    end
  end

  // ---------------- result sink readiness ----------------
  int out_gap = 0;
  int hold_n = 0;

  always @(negedge clk_i) begin
    if (hold_go && hold_n < HOLD_LEN) begin
      hold_n++;
      res.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      res.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 9);
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  // ---------------- monitor ----------------
  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d, want %0d (t=%0t)", what, got, want, $realtime);
    n_err++;
  endtask

  int idle_n = 0;

  always @(posedge clk_i) begin
    in_taken <= smp.valid && smp.ready;
    if (smp.valid && smp.ready)
      predict_transfer('{op: smp.opcode, tst: smp.test_sample, rfs: smp.ref_sample});
    if (res.valid && res.ready) begin
      if (result_q.size() == 0) begin
        report("unexpected result transfer, plane", res.plane, 0);
      end else begin
        ypm_pkg::out_item_t w;
        w = result_q.pop_front();
        if (res.plane !== w.plane) report("plane", res.plane, w.plane);
        if (res.is_summary !== w.is_summary) report("is_summary", res.is_summary, w.is_summary);
        if (res.error_sum !== w.error_sum) report("error_sum", res.error_sum, w.error_sum);
        if (res.psnr_q8 !== w.psnr_q8) report("psnr_q8", res.psnr_q8, w.psnr_q8);
        if (res.mean_psnr_q8 !== w.mean_psnr_q8)
          report("mean_psnr_q8", res.mean_psnr_q8, w.mean_psnr_q8);
        if (res.frame_number !== w.frame_number)
          report("frame_number", res.frame_number, w.frame_number);
        if (res.zero_error !== w.zero_error) report("zero_error", res.zero_error, w.zero_error);
        if (res.no_frames !== w.no_frames) report("no_frames", res.no_frames, w.no_frames);
        if (res.last !== w.last) report("last", res.last, w.last);
      end
    end
    if ((smp.valid && smp.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      idle_n = 0;
    else if (rst_ni) begin
      idle_n++;
      if (idle_n == WDOG_LIMIT) begin
        $display("yuv420_psnr_meter_unit_test: done, errors");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic pair_t make_pair(int mode);
    pair_t it;
    it.op = ypm_pkg::OP_SAMPLE;
    it.tst = $urandom_range(0, 255);
    case (mode)
      0: it.rfs = it.tst;
      1: it.rfs = it.tst ^ 8'($urandom_range(0, 3));
      3: begin
        it.tst = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        it.rfs = ~it.tst;
      end
      default: it.rfs = $urandom_range(0, 255);
    endcase
    return it;
  endfunction

  task automatic push_samples(int n, int mode);
    repeat (n) pair_q.push_back(make_pair(mode));
  endtask

  task automatic push_frame(int mode);
    int unsigned w, h;
    w = clamp_dim(wid_r);
    h = clamp_dim(hgt_r);
    push_samples(w * h + 2 * (w >> 1) * (h >> 1), mode);
  endtask

  task automatic push_finish();
    pair_t it;
    it.op = ypm_pkg::OP_FINISH;
    it.tst = $urandom_range(0, 255);
    it.rfs = $urandom_range(0, 255);
    pair_q.push_back(it);
  endtask

  task automatic settle();
    do @(posedge clk_i); while (pair_q.size() != 0 || smp.valid || result_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      ypm_pkg::CFG_WIDTH:  begin wid_r = val[12:0]; clear_pos(); end
      ypm_pkg::CFG_HEIGHT: begin hgt_r = val[12:0]; clear_pos(); end
      ypm_pkg::CFG_PEAK:   peak_r = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    int n_rand, nf;
    smp.valid = 1'b0; smp.opcode = ypm_pkg::OP_SAMPLE;
    smp.test_sample = '0; smp.ref_sample = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0; cfg.index = ypm_pkg::CFG_WIDTH; cfg.data = '0;
    wid_r = 13'd352; hgt_r = 13'd288; peak_r = 16'd65025;
    clear_all();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // finish on an empty video, then a partial frame that finish throws away
    push_finish();
    push_samples(5, 2);
    push_finish();
    settle();

    // smallest frame: equal samples, extreme differences, a stray partial frame
    write_reg(ypm_pkg::CFG_WIDTH, 16'd0);
    write_reg(ypm_pkg::CFG_HEIGHT, 16'd1);
    push_frame(0);
    push_frame(3);
    push_samples(5, 2);
    push_finish();
    settle();

    // zero and all-ones peak, odd dimensions
    write_reg(ypm_pkg::CFG_PEAK, 16'd0);
    write_reg(ypm_pkg::CFG_WIDTH, 16'd3);
    write_reg(ypm_pkg::CFG_HEIGHT, 16'd3);
    push_frame(2);
    push_frame(0);
    push_samples(4, 2);
    settle();
    // register write in the middle of a frame drops its position
    write_reg(ypm_pkg::CFG_PEAK, 16'hFFFF);
    write_reg(ypm_pkg::CFG_WIDTH, 16'd2);
    push_frame(1);
    push_finish();
    settle();

    // oversized width clamps, so a short run of samples ends no plane
    write_reg(ypm_pkg::CFG_PEAK, 16'd1);
    write_reg(ypm_pkg::CFG_WIDTH, 16'hFFFF);
    write_reg(ypm_pkg::CFG_HEIGHT, 16'd2);
    push_samples(20, 1);
    settle();
    write_reg(ypm_pkg::CFG_PEAK, 16'd65025);
    write_reg(ypm_pkg::CFG_WIDTH, 16'd2);
    write_reg(ypm_pkg::CFG_HEIGHT, 16'd4);
    push_frame(2);
    push_finish();
    settle();

    // random phases; the first one stalls the result side for a long stretch
    n_rand = 0;
    while (n_rand < 250) begin
      if (n_rand > 190) quiet = 1'b1;
      write_reg(ypm_pkg::CFG_WIDTH, 16'($urandom_range(0, 7)));
      write_reg(ypm_pkg::CFG_HEIGHT, 16'($urandom_range(0, 7)));
      case ($urandom_range(0, 4))
        0: write_reg(ypm_pkg::CFG_PEAK, 16'($urandom_range(0, 1)));
        1: write_reg(ypm_pkg::CFG_PEAK, 16'd65025);
        default: write_reg(ypm_pkg::CFG_PEAK, 16'($urandom));
      endcase
      nf = $urandom_range(1, 4);
      if (n_rand == 0) begin
        nf = 3;
        hold_go = 1'b1;
      end
      repeat (nf) begin
        int before_n;
        before_n = pair_q.size();
        push_frame($urandom_range(0, 3));
        n_rand += pair_q.size() - before_n;
      end
      if ($urandom_range(0, 2) == 0) begin
        push_samples($urandom_range(1, 6), 2);
        n_rand += 3;
      end
      if ($urandom_range(0, 3) != 0) begin
        push_finish();
        n_rand++;
      end
      settle();
    end
    push_finish();
    settle();

    if (n_err == 0) $display("yuv420_psnr_meter_unit_test: done, clean");
    else $display("yuv420_psnr_meter_unit_test: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ypm_pkg.sv
rtl/ypm_if.sv
rtl/ypm_math.sv
rtl/yuv420_psnr_meter_unit.sv
tb/yuv420_psnr_meter_unit_test.sv
